### hw/rtl/uer_pkg.sv
package uer_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam int TRIG_W = 8;
  localparam int TIMEOUT_W = 16;
  localparam int WIDTH_W = 16;
  localparam int DIST_W = 11;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [TRIG_W-1:0] TRIGGER_TICKS_RST = 8'd20;
  localparam logic [TIMEOUT_W-1:0] RISE_TIMEOUT_RST = 16'd1000;
  localparam logic [TIMEOUT_W-1:0] ECHO_TIMEOUT_RST = 16'd30000;

  // Division by 58 as a multiply by ceil(2^22 / 58) and a shift; exact for 16-bit widths.
  localparam int RECIP_W = 17;
  localparam logic [RECIP_W-1:0] CM_RECIP = 17'd72316;
  localparam int CM_SHIFT = 22;
  localparam int PROD_W = WIDTH_W + RECIP_W;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_TRIGGER_TICKS = 2'd0,
    CFG_RISE_TIMEOUT  = 2'd1,
    CFG_ECHO_TIMEOUT  = 2'd2,
    CFG_UNUSED        = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_TRIG = 2'd1,
    PH_RISE = 2'd2,
    PH_HIGH = 2'd3
  } phase_t;

endpackage

### hw/rtl/ultrasonic_echo_ranger.sv
// Ultrasonic range measurement controller for an HC-SR04 style sensor.
// The input channel (in_valid, in_stall) carries one transaction per
// microsecond tick with start_req and the sampled echo_level. Every input
// transaction produces exactly one output transaction on (out_valid,
// out_stall) with the trigger pin level, done and failure flags, the echo
// width in microseconds, the distance in centimeters and the busy flag.
// The result of a tick appears in the cycle after it is accepted. A new tick
// can be accepted in every cycle, one tick per clock, unless the receiver stalls.
// The result register is the only buffer: while the receiver stalls and a
// result is waiting, in_stall is raised and no further tick is taken.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 sets the trigger length, 1 the rise timeout and 2 the
// echo timeout. Writes to other indexes are dropped.
// A synchronous reset returns the controller to idle, clears the pending
// result and restores the default configuration of 20, 1000 and 30000.
module ultrasonic_echo_ranger #(
  parameter int COUNT_WIDTH = uer_pkg::COUNT_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           start_req,
  input  logic                           echo_level,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           trigger_level,
  output logic                           done_res,
  output logic                           failed,
  output logic [uer_pkg::WIDTH_W-1:0]    width_us,
  output logic [uer_pkg::DIST_W-1:0]     distance_cm,
  output logic                           busy_res,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int CMP_W = (COUNT_WIDTH + 1 > uer_pkg::TIMEOUT_W) ?
                         COUNT_WIDTH + 1 : uer_pkg::TIMEOUT_W;

  logic [uer_pkg::TRIG_W-1:0]    trigger_ticks;
  logic [uer_pkg::TIMEOUT_W-1:0] rise_timeout;
  logic [uer_pkg::TIMEOUT_W-1:0] echo_limit;

  uer_pkg::phase_t           phase;
  uer_pkg::phase_t           phase_next;
  logic [COUNT_WIDTH-1:0]    tick_count;
  logic [COUNT_WIDTH-1:0]    tick_count_next;

  logic                      accept;
  logic [COUNT_WIDTH:0]      count_inc;
  logic [CMP_W-1:0]          count_inc_cmp;
  logic                      trig_done;
  logic                      rise_fail;
  logic                      high_fail;
  logic                      first_high_fail;

  logic                      trig_d;
  logic                      done_d;
  logic                      fail_d;
  logic [uer_pkg::WIDTH_W-1:0] width_d;
  logic [uer_pkg::PROD_W-1:0]  dist_prod;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid & out_stall;
  assign accept    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_ticks <= uer_pkg::TRIGGER_TICKS_RST;
      rise_timeout  <= uer_pkg::RISE_TIMEOUT_RST;
      echo_limit    <= uer_pkg::ECHO_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (uer_pkg::cfg_index_t'(cfg_index))
        uer_pkg::CFG_TRIGGER_TICKS: trigger_ticks <= cfg_data[uer_pkg::TRIG_W-1:0];
        uer_pkg::CFG_RISE_TIMEOUT:  rise_timeout  <= cfg_data;
        uer_pkg::CFG_ECHO_TIMEOUT:  echo_limit    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign count_inc     = {1'b0, tick_count} + {{COUNT_WIDTH{1'b0}}, 1'b1};
  assign count_inc_cmp = CMP_W'(count_inc);

  assign trig_done = (CMP_W'(count_inc[COUNT_WIDTH-1:0]) >= CMP_W'(trigger_ticks)) ||
                     (count_inc[COUNT_WIDTH-1:0] == '0);
  assign rise_fail = (count_inc_cmp > CMP_W'(rise_timeout)) || count_inc[COUNT_WIDTH];
  assign high_fail = (count_inc_cmp > CMP_W'(echo_limit)) || count_inc[COUNT_WIDTH];
  assign first_high_fail = (echo_limit == '0);

  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    unique case (phase)
      uer_pkg::PH_IDLE: begin
        tick_count_next = '0;
        if (start_req) begin
          if (trigger_ticks <= uer_pkg::TRIG_W'(1)) begin
            phase_next = uer_pkg::PH_RISE;
          end else begin
            phase_next      = uer_pkg::PH_TRIG;
            tick_count_next = COUNT_WIDTH'(1);
          end
        end
      end
      uer_pkg::PH_TRIG: begin
        if (trig_done) begin
          phase_next      = uer_pkg::PH_RISE;
          tick_count_next = '0;
        end else begin
          tick_count_next = count_inc[COUNT_WIDTH-1:0];
        end
      end
      uer_pkg::PH_RISE: begin
        if (echo_level) begin
          if (first_high_fail) begin
            phase_next      = uer_pkg::PH_IDLE;
            tick_count_next = '0;
          end else begin
            phase_next      = uer_pkg::PH_HIGH;
            tick_count_next = COUNT_WIDTH'(1);
          end
        end else if (rise_fail) begin
          phase_next      = uer_pkg::PH_IDLE;
          tick_count_next = '0;
        end else begin
          tick_count_next = count_inc[COUNT_WIDTH-1:0];
        end
      end
      uer_pkg::PH_HIGH: begin
        if (echo_level && !high_fail) begin
          tick_count_next = count_inc[COUNT_WIDTH-1:0];
        end else begin
          phase_next      = uer_pkg::PH_IDLE;
          tick_count_next = '0;
        end
      end
      default: begin
        phase_next      = uer_pkg::PH_IDLE;
        tick_count_next = '0;
      end
    endcase
  end

  always_comb begin
    trig_d  = 1'b0;
    done_d  = 1'b0;
    fail_d  = 1'b0;
    width_d = '0;
    unique case (phase)
      uer_pkg::PH_IDLE: begin
        trig_d = start_req;
      end
      uer_pkg::PH_TRIG: begin
        trig_d = 1'b1;
      end
      uer_pkg::PH_RISE: begin
        if (echo_level) begin
          done_d = first_high_fail;
          fail_d = first_high_fail;
        end else begin
          done_d = rise_fail;
          fail_d = rise_fail;
        end
      end
      uer_pkg::PH_HIGH: begin
        if (echo_level) begin
          done_d = high_fail;
          fail_d = high_fail;
        end else begin
          done_d  = 1'b1;
          width_d = uer_pkg::WIDTH_W'(tick_count);
        end
      end
      default: begin
      end
    endcase
  end

  assign dist_prod = uer_pkg::PROD_W'(width_d) * uer_pkg::PROD_W'(uer_pkg::CM_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= uer_pkg::PH_IDLE;
      tick_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        phase      <= phase_next;
        tick_count <= tick_count_next;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      trigger_level <= trig_d;
      done_res      <= done_d;
      failed        <= fail_d;
      width_us      <= width_d;
      distance_cm   <= uer_pkg::DIST_W'(dist_prod >> uer_pkg::CM_SHIFT);
      busy_res      <= (phase_next != uer_pkg::PH_IDLE);
    end
  end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import uer_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int TICKS_PER_PHASE = 100;
  localparam int CM_DIVISOR = 58;

  typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

  typedef struct packed {
    logic start;
    logic echo;
  } tick_t;

  typedef struct packed {
    logic                trigger;
    logic                done;
    logic                fail;
    logic [WIDTH_W-1:0]  width;
    logic [DIST_W-1:0]   distance;
    logic                busy;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic start_req = 1'b0;
  logic echo_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic trigger_level;
  logic done_res;
  logic failed;
  logic [WIDTH_W-1:0] width_us;
  logic [DIST_W-1:0] distance_cm;
  logic busy_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predicted state of the ranger and its configuration.
  phase_t rng_phase = PH_IDLE;
  logic [COUNT_WIDTH_DEF-1:0] rng_count = '0;
  logic [TRIG_W-1:0] trig_ticks = TRIGGER_TICKS_RST;
  logic [TIMEOUT_W-1:0] rise_to = RISE_TIMEOUT_RST;
  logic [TIMEOUT_W-1:0] echo_to = ECHO_TIMEOUT_RST;

  tick_t pending_ticks[$];
  reading_t expected_readings[$];
  int queued_ticks = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  int send_gap_max = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_cnt = 0;
  stall_mode_t stall_mode = STALL_NONE;

  ultrasonic_echo_ranger i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic reading_t ranger_predict(logic start, logic echo);
    reading_t r;
    logic [COUNT_WIDTH_DEF:0] nxt;
    logic echo_counts;
    r = '0;
    echo_counts = 1'b0;
    nxt = {1'b0, rng_count} + 1'b1;
    case (rng_phase)
      PH_IDLE: begin
        rng_count = '0;
        if (start) begin
          r.trigger = 1'b1;
          if (trig_ticks <= 1) begin
            rng_phase = PH_RISE;
          end else begin
            rng_phase = PH_TRIG;
            rng_count = COUNT_WIDTH_DEF'(1);
          end
        end
      end
      PH_TRIG: begin
        r.trigger = 1'b1;
        rng_count = nxt[COUNT_WIDTH_DEF-1:0];
        if (rng_count >= trig_ticks || rng_count == 0) begin
          rng_phase = PH_RISE;
          rng_count = '0;
        end
      end
      PH_RISE: begin
        if (echo) begin
          rng_count = '0;
          echo_counts = 1'b1;
        end else if (nxt > rise_to || nxt[COUNT_WIDTH_DEF]) begin
          rng_phase = PH_IDLE;
          rng_count = '0;
          r.done = 1'b1;
          r.fail = 1'b1;
        end else begin
          rng_count = nxt[COUNT_WIDTH_DEF-1:0];
        end
      end
      default: begin
        if (echo) begin
          echo_counts = 1'b1;
        end else begin
          r.done = 1'b1;
          r.width = rng_count;
          r.distance = DIST_W'(rng_count / CM_DIVISOR);
          rng_phase = PH_IDLE;
          rng_count = '0;
        end
      end
    endcase
    if (echo_counts) begin
      nxt = {1'b0, rng_count} + 1'b1;
      if (nxt > echo_to || nxt[COUNT_WIDTH_DEF]) begin
        rng_phase = PH_IDLE;
        rng_count = '0;
        r.done = 1'b1;
        r.fail = 1'b1;
      end else begin
        rng_phase = PH_HIGH;
        rng_count = nxt[COUNT_WIDTH_DEF-1:0];
      end
    end
    r.busy = (rng_phase != PH_IDLE);
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  function automatic int pick_len(int limit, int lo, int cap);
    int r;
    r = $urandom_range(0, 9);
    if (limit + 1 > cap) return $urandom_range(lo, cap);
    if (r < 2) return limit + 1;
    if (r < 4) return limit;
    return $urandom_range(lo, (limit < lo) ? lo : limit);
  endfunction

  function automatic int pick_cfg(int common, int wider, int full);
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(1, common);
    if (r < 8) return $urandom_range(1, wider);
    return $urandom_range(1, full);
  endfunction

  function automatic void push_tick(logic start, logic echo);
    tick_t t;
    t.start = start;
    t.echo = echo;
    pending_ticks.push_back(t);
    queued_ticks++;
  endfunction

  // Start requests inside a measurement are ignored, so they are randomized
  // there, except after a timeout that has already returned the block to idle.
  function automatic void queue_measurement(int rise_wait, int high_len);
    int trig_len;
    bit rise_ok;
    bit high_ok;
    trig_len = (trig_ticks == 0) ? 1 : trig_ticks;
    rise_ok = (rise_wait <= rise_to);
    high_ok = (high_len <= echo_to);
    push_tick(1'b1, 1'($urandom_range(0, 1)));
    for (int i = 1; i < trig_len; i++) begin
      push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
    for (int i = 0; i < rise_wait; i++) begin
      push_tick(rise_ok & 1'($urandom_range(0, 1)), 1'b0);
    end
    for (int i = 0; i < high_len; i++) begin
      push_tick(high_ok & 1'($urandom_range(0, 1)), 1'b1);
    end
    if (rise_ok && high_len > 0) push_tick(high_ok & 1'($urandom_range(0, 1)), 1'b0);
  endfunction

  task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      CFG_TRIGGER_TICKS: trig_ticks = val[TRIG_W-1:0];
      CFG_RISE_TIMEOUT:  rise_to = val;
      CFG_ECHO_TIMEOUT:  echo_to = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_ticks.size() != 0 || in_valid || expected_readings.size() != 0);
  endtask

  always @(posedge clk) begin : drive
    tick_t tick;
    if (rst) begin
      in_valid <= 1'b0;
      start_req <= 1'b0;
      echo_level <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!(in_valid && in_stall)) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_ticks.size() > 0) begin
        tick = pending_ticks.pop_front();
        in_valid <= 1'b1;
        start_req <= tick.start;
        echo_level <= tick.echo;
        if (burst_left > 1) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(1, 24);
          gap_left <= (send_gap_max == 0 || $urandom_range(0, 3) == 0) ?
                      0 : $urandom_range(1, send_gap_max);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : receive
    if (rst) begin
      out_stall <= 1'b0;
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      case (stall_mode)
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 3) == 0);
        STALL_PERIODIC: out_stall <= (stall_cnt % 11) >= 7;
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  // Every accepted tick transaction yields one reading transaction, in order.
  always @(posedge clk) begin : monitor
    reading_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_readings.push_back(ranger_predict(start_req, echo_level));
      end
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $error("unexpected result transaction");
          fail_count++;
        end else begin
          want = expected_readings.pop_front();
          check_field("trigger_level", 32'(want.trigger), 32'(trigger_level));
          check_field("done_res", 32'(want.done), 32'(done_res));
          check_field("failed", 32'(want.fail), 32'(failed));
          check_field("width_us", 32'(want.width), 32'(width_us));
          check_field("distance_cm", 32'(want.distance), 32'(distance_cm));
          check_field("busy_res", 32'(want.busy), 32'(busy_res));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int rw;
    int hl;
    int target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset configuration, with starts and echo noise during the trigger.
    send_gap_max = 3;
    stall_mode = STALL_RANDOM;
    queue_measurement(3, 58);
    push_tick(1'b0, 1'b1);
    drain();

    write_reg(CFG_TRIGGER_TICKS, 16'd1);
    write_reg(CFG_RISE_TIMEOUT, 16'd2);
    write_reg(CFG_ECHO_TIMEOUT, 16'd3);
    stall_mode = STALL_PERIODIC;
    @(negedge clk);
    queue_measurement(0, 1);
    queue_measurement(2, 3);
    queue_measurement(3, 0);
    queue_measurement(0, 4);
    drain();

    // Zero settings: one-tick trigger and timeouts that fail at once.
    write_reg(CFG_TRIGGER_TICKS, 16'd0);
    write_reg(CFG_RISE_TIMEOUT, 16'd0);
    write_reg(CFG_ECHO_TIMEOUT, 16'd0);
    write_reg(CFG_UNUSED, 16'hFFFF);
    @(negedge clk);
    queue_measurement(0, 1);
    queue_measurement(1, 0);
    drain();

    // Echo exactly as long as the timeout allows, then one tick past it.
    write_reg(CFG_TRIGGER_TICKS, 16'd40);
    write_reg(CFG_RISE_TIMEOUT, 16'hFFFF);
    write_reg(CFG_ECHO_TIMEOUT, 16'd58);
    send_gap_max = 0;
    stall_mode = STALL_NONE;
    @(negedge clk);
    queue_measurement(2, 58);
    queue_measurement(0, 59);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      write_reg(CFG_TRIGGER_TICKS, CFG_DATA_W'(pick_cfg(6, 40, 255)));
      write_reg(CFG_RISE_TIMEOUT, CFG_DATA_W'(pick_cfg(30, 300, 65535)));
      write_reg(CFG_ECHO_TIMEOUT, CFG_DATA_W'(pick_cfg(150, 2000, 65535)));
      if (ph == 3) begin
        send_gap_max = 0;
        stall_mode = STALL_NONE;
      end else begin
        send_gap_max = $urandom_range(1, 6);
        stall_mode = (ph % 2 == 0) ? STALL_RANDOM : STALL_PERIODIC;
      end
      @(negedge clk);
      target = queued_ticks + TICKS_PER_PHASE;
      while (queued_ticks < target) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(4, 20)) begin
            push_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
          end
        end else begin
          rw = pick_len(rise_to, 0, 40);
          hl = (rw > rise_to) ? 0 : pick_len(echo_to, 1, 300);
          queue_measurement(rw, hl);
        end
        repeat ($urandom_range(0, 3)) push_tick(1'b0, 1'($urandom_range(0, 1)));
      end
      drain();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0 && expected_readings.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
